FILE: design/max_segment_tree_engine_top_defines.svh
// Assertion macros shared by the segment tree engine modules.
// Each use expects signals named clk and arst_n in the enclosing module.
`ifndef MAX_SEGMENT_TREE_ENGINE_TOP_DEFINES_SVH
`define MAX_SEGMENT_TREE_ENGINE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define MSTE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define MSTE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MSTE_ASSERT(lbl, prop, msg)
`define MSTE_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: design/mste_pkg.sv
package mste_pkg;

	localparam logic [2:0] REQ_WRITE  = 3'd0;
	localparam logic [2:0] REQ_READ   = 3'd1;
	localparam logic [2:0] REQ_RANGE  = 3'd2;
	localparam logic [2:0] REQ_SRIGHT = 3'd3;
	localparam logic [2:0] REQ_SLEFT  = 3'd4;

	localparam logic signed [31:0] VAL_IDENT = -32'sd1;
	localparam logic [10:0] ELEM_RESET = 11'd1024;

	typedef logic [4:0] op_t;

	localparam op_t OP_NOP      = 5'd0;
	localparam op_t OP_CLR      = 5'd1;
	localparam op_t OP_LOAD     = 5'd2;
	localparam op_t OP_PUSH     = 5'd3;
	localparam op_t OP_WLEAF    = 5'd4;
	localparam op_t OP_RD_SIB   = 5'd5;
	localparam op_t OP_WPAR     = 5'd6;
	localparam op_t OP_RD_L     = 5'd7;
	localparam op_t OP_FIN_RD   = 5'd8;
	localparam op_t OP_RM_RDL   = 5'd9;
	localparam op_t OP_RM_RDR   = 5'd10;
	localparam op_t OP_RM_SHIFT = 5'd11;
	localparam op_t OP_ACC      = 5'd12;
	localparam op_t OP_FIN_ACC  = 5'd13;
	localparam op_t OP_SHR_L    = 5'd14;
	localparam op_t OP_ACC_INC  = 5'd15;
	localparam op_t OP_ACC_DEC  = 5'd16;
	localparam op_t OP_DEC_L    = 5'd17;
	localparam op_t OP_DN_R     = 5'd18;
	localparam op_t OP_DN_L     = 5'd19;
	localparam op_t OP_FIN_N    = 5'd20;
	localparam op_t OP_FIN_SR   = 5'd21;
	localparam op_t OP_FIN_SL   = 5'd22;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic       clr_last;
		logic       ok;
		logic [2:0] req_type;
		logic       pos_eq_n;
		logic       pos_zero;
		logic       l_gt1;
		logic       l_odd;
		logic       r_odd;
		logic       l_lt_r;
		logic       l_lt_t;
		logic       l_pow2;
		logic       hit;
		logic       out_free;
	} sts_t;

endpackage

FILE: design/mste_ram.sv
module mste_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

FILE: design/mste_ctrl.sv
`include "max_segment_tree_engine_top_defines.svh"

module mste_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  mste_pkg::sts_t sts,
	output mste_pkg::cmd_t cmd
);

	localparam logic [4:0] S_CLR       = 5'd0;
	localparam logic [4:0] S_IDLE      = 5'd1;
	localparam logic [4:0] S_DISP      = 5'd2;
	localparam logic [4:0] S_DONE      = 5'd3;
	localparam logic [4:0] S_WLEAF     = 5'd4;
	localparam logic [4:0] S_W_TEST    = 5'd5;
	localparam logic [4:0] S_W_PAR     = 5'd6;
	localparam logic [4:0] S_RD_WAIT   = 5'd7;
	localparam logic [4:0] S_RM_TEST   = 5'd8;
	localparam logic [4:0] S_RM_LW     = 5'd9;
	localparam logic [4:0] S_RM_RTEST  = 5'd10;
	localparam logic [4:0] S_RM_RW     = 5'd11;
	localparam logic [4:0] S_RM_SH     = 5'd12;
	localparam logic [4:0] S_SR_UP     = 5'd13;
	localparam logic [4:0] S_SR_CHK    = 5'd14;
	localparam logic [4:0] S_SR_LCHK   = 5'd15;
	localparam logic [4:0] S_SR_DN     = 5'd16;
	localparam logic [4:0] S_SR_DCHK   = 5'd17;
	localparam logic [4:0] S_SL_DEC    = 5'd18;
	localparam logic [4:0] S_SL_UP     = 5'd19;
	localparam logic [4:0] S_SL_CHK    = 5'd20;
	localparam logic [4:0] S_SL_LCHK   = 5'd21;
	localparam logic [4:0] S_SL_DN     = 5'd22;
	localparam logic [4:0] S_SL_DCHK   = 5'd23;

	logic [4:0] state_q;
	logic [4:0] state_d;
	mste_pkg::op_t op;

	assign in_stall = (state_q != S_IDLE);
	assign cmd.op = op;

	always_comb begin
		state_d = state_q;
		op = mste_pkg::OP_NOP;
		case (state_q)
			S_CLR: begin
				op = mste_pkg::OP_CLR;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					op = mste_pkg::OP_LOAD;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if (!sts.ok) begin
					state_d = S_DONE;
				end else begin
					case (sts.req_type)
						mste_pkg::REQ_WRITE: state_d = S_WLEAF;
						mste_pkg::REQ_READ: begin
							op = mste_pkg::OP_RD_L;
							state_d = S_RD_WAIT;
						end
						mste_pkg::REQ_RANGE: state_d = S_RM_TEST;
						mste_pkg::REQ_SRIGHT: begin
							if (sts.pos_eq_n) begin
								op = mste_pkg::OP_FIN_N;
								state_d = S_DONE;
							end else begin
								state_d = S_SR_UP;
							end
						end
						mste_pkg::REQ_SLEFT: begin
							if (sts.pos_zero) begin
								state_d = S_DONE;
							end else begin
								state_d = S_SL_DEC;
							end
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_WLEAF: begin
				op = mste_pkg::OP_WLEAF;
				state_d = S_W_TEST;
			end
			S_W_TEST: begin
				if (sts.l_gt1) begin
					op = mste_pkg::OP_RD_SIB;
					state_d = S_W_PAR;
				end else begin
					state_d = S_DONE;
				end
			end
			S_W_PAR: begin
				op = mste_pkg::OP_WPAR;
				state_d = S_W_TEST;
			end
			S_RD_WAIT: begin
				op = mste_pkg::OP_FIN_RD;
				state_d = S_DONE;
			end
			S_RM_TEST: begin
				if (!sts.l_lt_r) begin
					op = mste_pkg::OP_FIN_ACC;
					state_d = S_DONE;
				end else if (sts.l_odd) begin
					op = mste_pkg::OP_RM_RDL;
					state_d = S_RM_LW;
				end else begin
					state_d = S_RM_RTEST;
				end
			end
			S_RM_LW: begin
				op = mste_pkg::OP_ACC;
				state_d = S_RM_RTEST;
			end
			S_RM_RTEST: begin
				if (sts.r_odd) begin
					op = mste_pkg::OP_RM_RDR;
					state_d = S_RM_RW;
				end else begin
					op = mste_pkg::OP_RM_SHIFT;
					state_d = S_RM_TEST;
				end
			end
			S_RM_RW: begin
				op = mste_pkg::OP_ACC;
				state_d = S_RM_SH;
			end
			S_RM_SH: begin
				op = mste_pkg::OP_RM_SHIFT;
				state_d = S_RM_TEST;
			end
			S_SR_UP: begin
				if (!sts.l_odd) begin
					op = mste_pkg::OP_SHR_L;
				end else begin
					op = mste_pkg::OP_RD_L;
					state_d = S_SR_CHK;
				end
			end
			S_SR_CHK: begin
				if (sts.hit) begin
					state_d = S_SR_DN;
				end else begin
					op = mste_pkg::OP_ACC_INC;
					state_d = S_SR_LCHK;
				end
			end
			S_SR_LCHK: begin
				if (sts.l_pow2) begin
					op = mste_pkg::OP_FIN_N;
					state_d = S_DONE;
				end else begin
					state_d = S_SR_UP;
				end
			end
			S_SR_DN: begin
				if (sts.l_lt_t) begin
					op = mste_pkg::OP_DN_R;
					state_d = S_SR_DCHK;
				end else begin
					op = mste_pkg::OP_FIN_SR;
					state_d = S_DONE;
				end
			end
			S_SR_DCHK: begin
				if (!sts.hit) begin
					op = mste_pkg::OP_ACC_INC;
				end
				state_d = S_SR_DN;
			end
			S_SL_DEC: begin
				op = mste_pkg::OP_DEC_L;
				state_d = S_SL_UP;
			end
			S_SL_UP: begin
				if (sts.l_gt1 && sts.l_odd) begin
					op = mste_pkg::OP_SHR_L;
				end else begin
					op = mste_pkg::OP_RD_L;
					state_d = S_SL_CHK;
				end
			end
			S_SL_CHK: begin
				if (sts.hit) begin
					state_d = S_SL_DN;
				end else begin
					op = mste_pkg::OP_ACC;
					state_d = S_SL_LCHK;
				end
			end
			S_SL_LCHK: begin
				if (sts.l_pow2) begin
					state_d = S_DONE;
				end else begin
					state_d = S_SL_DEC;
				end
			end
			S_SL_DN: begin
				if (sts.l_lt_t) begin
					op = mste_pkg::OP_DN_L;
					state_d = S_SL_DCHK;
				end else begin
					op = mste_pkg::OP_FIN_SL;
					state_d = S_DONE;
				end
			end
			S_SL_DCHK: begin
				if (!sts.hit) begin
					op = mste_pkg::OP_ACC_DEC;
				end
				state_d = S_SL_DN;
			end
			S_DONE: begin
				if (sts.out_free) begin
					op = mste_pkg::OP_PUSH;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	`MSTE_ASSERT_NXT(a_accept_dispatch, in_valid && !in_stall, state_q == S_DISP, "accepted request not dispatched")
	`MSTE_ASSERT_NXT(a_push_idle, state_q == S_DONE && sts.out_free, state_q == S_IDLE, "result push did not return to idle")

endmodule

FILE: design/mste_dp.sv
`include "max_segment_tree_engine_top_defines.svh"

module mste_dp #(
	parameter int LEAVES = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mste_pkg::cmd_t      cmd,
	output mste_pkg::sts_t      sts,
	input  logic [2:0]          req_type,
	input  logic [10:0]         position,
	input  logic [9:0]          range_end,
	input  logic signed [31:0]  new_value,
	input  logic [30:0]         threshold,
	input  logic                cfg_wr_en,
	input  logic [10:0]         cfg_wr_data,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  value_out,
	output logic [10:0]         found_index,
	output logic                status
);

	localparam int TSIZE = 1 << $clog2(LEAVES);
	localparam int DEPTH = 2 * TSIZE;
	localparam int AW = $clog2(DEPTH);
	localparam int LW = AW + 1;
	localparam logic [LW-1:0] T_L = LW'(TSIZE);
	localparam logic [LW-1:0] ONE_L = LW'(1);

	logic [10:0]        elem_q;
	logic [2:0]         type_q;
	logic [10:0]        pos_q;
	logic signed [31:0] nv_q;
	logic [30:0]        thr_q;
	logic               ok_q;
	logic [LW-1:0]      l_q;
	logic [LW-1:0]      r_q;
	logic signed [31:0] acc_q;
	logic signed [31:0] val_q;
	logic [10:0]        fidx_q;
	logic               st_q;
	logic [AW-1:0]      clr_q;
	logic               out_valid_q;
	logic signed [31:0] out_val_q;
	logic [10:0]        out_fidx_q;
	logic               out_st_q;

	logic [10:0]        n_eff;
	logic [10:0]        re1;
	logic               ok_in;
	logic signed [31:0] rd_val;
	logic signed [31:0] mx;
	logic               hit;
	logic [LW-1:0]      l_dbl;
	logic [LW-1:0]      l_dbl1;
	logic [LW-1:0]      r_m1;
	logic               out_free;
	logic               ram_we;
	logic [AW-1:0]      ram_addr;
	logic [31:0]        ram_wdata;
	logic [31:0]        ram_rdata;

	assign n_eff = (32'(elem_q) > 32'(LEAVES)) ? 11'(LEAVES) : elem_q;
	assign re1 = {1'b0, range_end} + 11'd1;

	always_comb begin
		case (req_type)
			mste_pkg::REQ_WRITE, mste_pkg::REQ_READ: ok_in = (position < n_eff);
			mste_pkg::REQ_RANGE: ok_in = (position <= re1) && (re1 <= n_eff);
			mste_pkg::REQ_SRIGHT, mste_pkg::REQ_SLEFT: ok_in = (position <= n_eff);
			default: ok_in = 1'b0;
		endcase
	end

	assign rd_val = $signed(ram_rdata);
	assign mx = (acc_q > rd_val) ? acc_q : rd_val;
	assign hit = (mx >= $signed({1'b0, thr_q}));
	assign l_dbl = {l_q[LW-2:0], 1'b0};
	assign l_dbl1 = {l_q[LW-2:0], 1'b1};
	assign r_m1 = r_q - ONE_L;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		ram_we = 1'b0;
		ram_addr = l_q[AW-1:0];
		ram_wdata = nv_q;
		case (cmd.op)
			mste_pkg::OP_CLR: begin
				ram_we = 1'b1;
				ram_addr = clr_q;
				ram_wdata = mste_pkg::VAL_IDENT;
			end
			mste_pkg::OP_WLEAF: begin
				ram_we = 1'b1;
			end
			mste_pkg::OP_RD_SIB: ram_addr = {l_q[AW-1:1], ~l_q[0]};
			mste_pkg::OP_WPAR: begin
				ram_we = 1'b1;
				ram_addr = l_q[AW:1];
				ram_wdata = mx;
			end
			mste_pkg::OP_RM_RDR: ram_addr = r_m1[AW-1:0];
			mste_pkg::OP_DN_R: ram_addr = l_dbl[AW-1:0];
			mste_pkg::OP_DN_L: ram_addr = l_dbl1[AW-1:0];
			default: ram_addr = l_q[AW-1:0];
		endcase
	end

	mste_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.addr(ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		case (cmd.op)
			mste_pkg::OP_LOAD: begin
				type_q <= req_type;
				pos_q <= position;
				nv_q <= new_value;
				thr_q <= threshold;
				ok_q <= ok_in;
				l_q <= LW'(position) + T_L;
				r_q <= LW'(re1) + T_L;
				acc_q <= mste_pkg::VAL_IDENT;
				val_q <= '0;
				fidx_q <= '0;
				st_q <= !ok_in;
			end
			mste_pkg::OP_WLEAF: acc_q <= nv_q;
			mste_pkg::OP_WPAR: begin
				acc_q <= mx;
				l_q <= l_q >> 1;
			end
			mste_pkg::OP_FIN_RD: val_q <= rd_val;
			mste_pkg::OP_RM_RDL: l_q <= l_q + ONE_L;
			mste_pkg::OP_RM_RDR: r_q <= r_m1;
			mste_pkg::OP_RM_SHIFT: begin
				l_q <= l_q >> 1;
				r_q <= r_q >> 1;
			end
			mste_pkg::OP_ACC: acc_q <= mx;
			mste_pkg::OP_FIN_ACC: val_q <= acc_q;
			mste_pkg::OP_SHR_L: l_q <= l_q >> 1;
			mste_pkg::OP_ACC_INC: begin
				acc_q <= mx;
				l_q <= l_q + ONE_L;
			end
			mste_pkg::OP_ACC_DEC: begin
				acc_q <= mx;
				l_q <= l_q - ONE_L;
			end
			mste_pkg::OP_DEC_L: l_q <= l_q - ONE_L;
			mste_pkg::OP_DN_R: l_q <= l_dbl;
			mste_pkg::OP_DN_L: l_q <= l_dbl1;
			mste_pkg::OP_FIN_N: fidx_q <= n_eff;
			mste_pkg::OP_FIN_SR: fidx_q <= 11'(l_q - T_L);
			mste_pkg::OP_FIN_SL: fidx_q <= 11'(l_q + ONE_L - T_L);
			default: acc_q <= acc_q;
		endcase
		if (cmd.op == mste_pkg::OP_PUSH) begin
			out_val_q <= val_q;
			out_fidx_q <= fidx_q;
			out_st_q <= st_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_q <= mste_pkg::ELEM_RESET;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				elem_q <= cfg_wr_data;
			end
			if (cmd.op == mste_pkg::OP_CLR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.op == mste_pkg::OP_PUSH) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.clr_last = (clr_q == AW'(DEPTH - 1));
	assign sts.ok = ok_q;
	assign sts.req_type = type_q;
	assign sts.pos_eq_n = (pos_q == n_eff);
	assign sts.pos_zero = (pos_q == '0);
	assign sts.l_gt1 = (l_q > ONE_L);
	assign sts.l_odd = l_q[0];
	assign sts.r_odd = r_q[0];
	assign sts.l_lt_r = (l_q < r_q);
	assign sts.l_lt_t = (l_q < T_L);
	assign sts.l_pow2 = ((l_q & (l_q - ONE_L)) == '0);
	assign sts.hit = hit;
	assign sts.out_free = out_free;

	assign out_valid = out_valid_q;
	assign value_out = out_val_q;
	assign found_index = out_fidx_q;
	assign status = out_st_q;

	`MSTE_ASSERT(a_push_free, (cmd.op == mste_pkg::OP_PUSH) |-> out_free, "result pushed over a pending transaction")
	`MSTE_ASSERT(a_read_nonzero, (cmd.op == mste_pkg::OP_RD_L) |-> (l_q != '0), "tree read at node zero")

endmodule

FILE: design/max_segment_tree_engine_top.sv
// Range-maximum segment tree with threshold searches.
// Requests enter on in_valid/in_stall; a transaction is taken at a clock edge
// with in_valid high and in_stall low. Each request gives exactly one result
// transaction on out_valid/out_stall, in request order.
// The block works on one request at a time. The tree lives in one single-port
// RAM of 2*TSIZE words, and every node visit costs a RAM read whose registered
// data is then used, so that port sets the latency. The next request is taken
// once the controller has returned to idle after pushing the result to the
// output register.
// After reset the block clears all 2*TSIZE tree nodes (2048 for the default
// size) to -1, one word per cycle, and holds in_stall high meanwhile.
// elements_in_use resets to 1024 and is written through cfg_wr_en/cfg_wr_data;
// the user must write it only while the block is idle; the block does not enforce it.
// A finished result waits in the output register while out_stall is high; the
// next request may already be taken and worked on, and its result is held
// back until the output register is free.
module max_segment_tree_engine_top #(
	parameter int LEAVES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         req_type,
	input  logic [10:0]        position,
	input  logic [9:0]         range_end,
	input  logic signed [31:0] new_value,
	input  logic [30:0]        threshold,
	input  logic               cfg_wr_en,
	input  logic [10:0]        cfg_wr_data,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] value_out,
	output logic [10:0]        found_index,
	output logic               status
);

	mste_pkg::cmd_t cmd;
	mste_pkg::sts_t sts;

	mste_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts(sts),
		.cmd(cmd)
	);

	mste_dp #(
		.LEAVES(LEAVES)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.req_type(req_type),
		.position(position),
		.range_end(range_end),
		.new_value(new_value),
		.threshold(threshold),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.value_out(value_out),
		.found_index(found_index),
		.status(status)
	);

endmodule
